@@ sv/pidiz_pkg.sv @@
// Package for the PID controller with integral zone and settle timer.
// Holds command codes, register indexes, limits and the pipeline stage types.
// No dependencies.
package pidiz_pkg;

    // Commands carried by an input beat; code 3 has no meaning and changes nothing.
    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_START  = 2'd1,
        CMD_CHECK  = 2'd2
    } cmd_t;

    // Configuration port geometry and register indexes.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_WAIT_MS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RUN_TIMEOUT_MS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT       = 3'd5;

    // Error magnitude limits: integral collects below the zone, the settle
    // timer restarts above the band.
    localparam int INTEGRAL_ZONE = 20;
    localparam int SETTLE_BAND   = 80;

    localparam logic [16:0] ZONE_LIM = 17'(INTEGRAL_ZONE);
    localparam logic [16:0] BAND_LIM = 17'(SETTLE_BAND);

    // Operands handed from the state update stage to the multiply stage.
    typedef struct packed {
        logic               sample;
        logic signed [16:0] err;
        logic signed [17:0] diff;
        logic               err_zero;
        logic signed [31:0] integ;
        logic               moving;
    } op_t;

    // Exact products handed from the multiply stage to the sum stage.
    typedef struct packed {
        logic               sample;
        logic signed [16:0] err;
        logic signed [32:0] p_prod;
        logic signed [47:0] i_prod;
        logic signed [33:0] d_prod;
        logic               moving;
    } prod_t;

endpackage

@@ sv/pid_with_integral_zone_and_settle_top.sv @@
// Top level of the PID controller with integral zone and settle timer.
// Depends on pidiz_pkg for command codes, register indexes and stage types.
//
// A result beat passes the input register, then the operand, product and output registers.
// Throughput: one beat per cycle; the pipeline only stops when the output stalls.
// Four stages: input register, state update, three multipliers, sum and saturate.
// Reset: pipeline empty, configuration registers and state zero, moving flag set; no clear pass.
module pid_with_integral_zone_and_settle_top
(
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  cfg_wr_en,
    input  logic [pidiz_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pidiz_pkg::CFG_DATA_W-1:0]      cfg_data,

    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [1:0]                            cmd,
    input  logic signed [15:0]                    measured,
    input  logic [31:0]                           now_ms,

    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [31:0]                    drive,
    output logic signed [16:0]                    error_out,
    output logic                                  moving
);

    // Configuration registers.
    logic signed [15:0] gain_p_reg;
    logic signed [15:0] gain_i_reg;
    logic signed [15:0] gain_d_reg;
    logic [31:0]        settle_wait_reg;
    logic [31:0]        run_timeout_reg;
    logic signed [15:0] setpoint_reg;

    // Controller state.
    logic signed [31:0] integral_sum_reg, integral_sum_next;
    logic signed [16:0] last_error_reg, last_error_next;
    logic [31:0]        stable_since_reg, stable_since_next;
    logic [31:0]        run_start_reg, run_start_next;
    logic               moving_flag_reg, moving_flag_next;

    // Pipeline registers.
    logic               s0_vld_reg;
    logic [1:0]         s0_cmd_reg;
    logic signed [15:0] s0_meas_reg;
    logic [31:0]        s0_now_reg;

    logic               s1_vld_reg;
    pidiz_pkg::op_t     s1_reg, s1_next;

    logic               s2_vld_reg;
    pidiz_pkg::prod_t   s2_reg, s2_next;

    logic               out_vld_reg;
    logic signed [31:0] drive_reg, drive_next;
    logic signed [16:0] error_reg;
    logic               moving_out_reg;

    // Handshake chain from the output back to the input.
    logic s3_rdy, s2_rdy, s1_rdy;
    logic s0_adv, s1_adv, s2_adv;

    assign s3_rdy   = !out_vld_reg || out_ready;
    assign s2_rdy   = !s2_vld_reg || s3_rdy;
    assign s1_rdy   = !s1_vld_reg || s2_rdy;
    assign in_ready = !s0_vld_reg || s1_rdy;

    assign s0_adv = s0_vld_reg && s1_rdy;
    assign s1_adv = s1_vld_reg && s2_rdy;
    assign s2_adv = s2_vld_reg && s3_rdy;

    // Error, its magnitude and the running integral for this sample.
    logic signed [16:0] err;
    logic [16:0]        err_abs;
    logic [16:0]        last_err_abs;
    logic               in_zone;
    logic signed [32:0] integ_sum;
    logic signed [31:0] integ_sat;
    logic signed [31:0] integ_new;
    logic signed [17:0] diff;
    logic [31:0]        settle_elapsed;
    logic [31:0]        run_elapsed;
    logic               settle_expired;
    logic               run_expired;

    always_comb
    begin
        err          = 17'(setpoint_reg) - 17'(s0_meas_reg);
        err_abs      = err[16] ? 17'(-err) : 17'(err);
        last_err_abs = last_error_reg[16] ? 17'(-last_error_reg) : 17'(last_error_reg);
        in_zone      = (err != 17'sd0) && (err_abs < pidiz_pkg::ZONE_LIM);

        integ_sum = 33'(integral_sum_reg) + 33'(err);
        if (integ_sum[32] != integ_sum[31])
        begin
            integ_sat = integ_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else
        begin
            integ_sat = integ_sum[31:0];
        end
        integ_new = in_zone ? integ_sat : 32'sd0;

        diff = 18'(err) - 18'(last_error_reg);

        settle_elapsed = s0_now_reg - stable_since_reg;
        run_elapsed    = s0_now_reg - run_start_reg;
        settle_expired = settle_elapsed > settle_wait_reg;
        run_expired    = run_elapsed > run_timeout_reg;
    end

    // Command decode: next controller state and the operands for the multipliers.
    always_comb
    begin
        integral_sum_next = integral_sum_reg;
        last_error_next   = last_error_reg;
        stable_since_next = stable_since_reg;
        run_start_next    = run_start_reg;
        moving_flag_next  = moving_flag_reg;

        case (s0_cmd_reg)
            pidiz_pkg::CMD_SAMPLE:
            begin
                if (settle_expired)
                begin
                    moving_flag_next = 1'b0;
                end
                integral_sum_next = integ_new;
                last_error_next   = err;
                if (err_abs > pidiz_pkg::BAND_LIM)
                begin
                    stable_since_next = s0_now_reg;
                end
            end
            pidiz_pkg::CMD_START:
            begin
                run_start_next    = s0_now_reg;
                stable_since_next = s0_now_reg;
                moving_flag_next  = 1'b1;
            end
            pidiz_pkg::CMD_CHECK:
            begin
                if (run_expired)
                begin
                    moving_flag_next = 1'b0;
                end
            end
            default:
            begin
                moving_flag_next = moving_flag_reg;
            end
        endcase

        s1_next.sample   = (s0_cmd_reg == pidiz_pkg::CMD_SAMPLE);
        s1_next.err      = s1_next.sample ? err : 17'sd0;
        s1_next.diff     = diff;
        s1_next.err_zero = (err == 17'sd0);
        s1_next.integ    = integ_new;
        s1_next.moving   = moving_flag_next;
    end

    // Exact products of the three terms.
    always_comb
    begin
        s2_next.sample = s1_reg.sample;
        s2_next.err    = s1_reg.err;
        s2_next.p_prod = 33'(s1_reg.err) * 33'(gain_p_reg);
        s2_next.i_prod = 48'(s1_reg.integ) * 48'(gain_i_reg);
        s2_next.d_prod = s1_reg.err_zero ? 34'sd0 : 34'(s1_reg.diff) * 34'(gain_d_reg);
        s2_next.moving = s1_reg.moving;
    end

    // Divide each product by 256 toward zero, sum exactly and saturate; a beat that is not a sample drives zero.
    logic signed [32:0] p_adj;
    logic signed [47:0] i_adj;
    logic signed [33:0] d_adj;
    logic signed [41:0] total;
    logic               total_fits;

    always_comb
    begin
        p_adj = s2_reg.p_prod + (s2_reg.p_prod[32] ? 33'sd255 : 33'sd0);
        i_adj = s2_reg.i_prod + (s2_reg.i_prod[47] ? 48'sd255 : 48'sd0);
        d_adj = s2_reg.d_prod + (s2_reg.d_prod[33] ? 34'sd255 : 34'sd0);

        total = 42'($signed(p_adj[32:8])) + 42'($signed(i_adj[47:8]))
              + 42'($signed(d_adj[33:8]));
        total_fits = (total[41:31] == {11{total[31]}});

        if (!s2_reg.sample)
        begin
            drive_next = 32'sd0;
        end
        else if (total_fits)
        begin
            drive_next = total[31:0];
        end
        else
        begin
            drive_next = total[41] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
    end

    // Control state, configuration and controller state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg       <= 1'b0;
            s1_vld_reg       <= 1'b0;
            s2_vld_reg       <= 1'b0;
            out_vld_reg      <= 1'b0;
            gain_p_reg       <= '0;
            gain_i_reg       <= '0;
            gain_d_reg       <= '0;
            settle_wait_reg  <= '0;
            run_timeout_reg  <= '0;
            setpoint_reg     <= '0;
            integral_sum_reg <= '0;
            last_error_reg   <= '0;
            stable_since_reg <= '0;
            run_start_reg    <= '0;
            moving_flag_reg  <= 1'b1;
        end
        else
        begin
            if (in_ready)
            begin
                s0_vld_reg <= in_valid;
            end
            if (s1_rdy)
            begin
                s1_vld_reg <= s0_vld_reg;
            end
            if (s2_rdy)
            begin
                s2_vld_reg <= s1_vld_reg;
            end
            if (s3_rdy)
            begin
                out_vld_reg <= s2_vld_reg;
            end

            if (s0_adv)
            begin
                integral_sum_reg <= integral_sum_next;
                last_error_reg   <= last_error_next;
                stable_since_reg <= stable_since_next;
                run_start_reg    <= run_start_next;
                moving_flag_reg  <= moving_flag_next;
            end

            if (cfg_wr_en)
            begin
                case (cfg_index)
                    pidiz_pkg::REG_GAIN_P:         gain_p_reg      <= cfg_data[15:0];
                    pidiz_pkg::REG_GAIN_I:         gain_i_reg      <= cfg_data[15:0];
                    pidiz_pkg::REG_GAIN_D:         gain_d_reg      <= cfg_data[15:0];
                    pidiz_pkg::REG_SETTLE_WAIT_MS: settle_wait_reg <= cfg_data;
                    pidiz_pkg::REG_RUN_TIMEOUT_MS: run_timeout_reg <= cfg_data;
                    pidiz_pkg::REG_SETPOINT:       setpoint_reg    <= cfg_data[15:0];
                    default:                       setpoint_reg    <= setpoint_reg;
                endcase
            end
        end
    end

    // Payload registers of each stage load when the stage takes a beat.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s0_cmd_reg  <= cmd;
            s0_meas_reg <= measured;
            s0_now_reg  <= now_ms;
        end
        if (s0_adv)
        begin
            s1_reg <= s1_next;
        end
        if (s1_adv)
        begin
            s2_reg <= s2_next;
        end
        if (s2_adv)
        begin
            drive_reg      <= drive_next;
            error_reg      <= s2_reg.err;
            moving_out_reg <= s2_reg.moving;
        end
    end

    assign out_valid = out_vld_reg;
    assign drive     = drive_reg;
    assign error_out = error_reg;
    assign moving    = moving_out_reg;

    // A stalled input means every stage holds a beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s0_vld_reg && s1_vld_reg && s2_vld_reg && out_vld_reg))
        else $error("input stalled while a pipeline stage is empty");

    // A nonzero integral can only come from a last error inside the zone.
    assert property (@(posedge clk) disable iff (!rst_n)
        (integral_sum_reg != 32'sd0) |->
            (last_error_reg != 17'sd0 && last_err_abs < pidiz_pkg::ZONE_LIM))
        else $error("integral held with last error outside the zone");

    // A start command always leaves the moving flag set.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s0_adv && s0_cmd_reg == pidiz_pkg::CMD_START) |=> moving_flag_reg)
        else $error("moving flag clear after a start");

    // A large error restarts the settle timer at the sample time.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s0_adv && s0_cmd_reg == pidiz_pkg::CMD_SAMPLE && err_abs > pidiz_pkg::BAND_LIM)
            |=> (stable_since_reg == $past(s0_now_reg)))
        else $error("settle timer not restarted on a large error");

endmodule
